// ===== design/air_sensor_frame_parser_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the air sensor frame parser
// Shared shorthand for the concurrent checks in the top level.
// ---------------------------------------------------------------------------
`ifndef AIR_SENSOR_FRAME_PARSER_TOP_MACROS_SVH
`define AIR_SENSOR_FRAME_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASFP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASFP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/asfp_pkg.sv =====
// ---------------------------------------------------------------------------
// Air sensor frame parser package
// Header codes, frame positions, phase encoding and the result record.
// ---------------------------------------------------------------------------
package asfp_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h3C;
  localparam logic [7:0] HDR_SECOND = 8'h02;
  localparam logic [4:0] LAST_INDEX = 5'd16;
  localparam logic [7:0] TEMP_MASK  = 8'h7F;

  // Frame positions whose bytes are kept.
  localparam logic [4:0] POS_CONC_HI  = 5'd6;
  localparam logic [4:0] POS_CONC_LO  = 5'd7;
  localparam logic [4:0] POS_TEMP_WH  = 5'd12;
  localparam logic [4:0] POS_TEMP_FR  = 5'd13;
  localparam logic [4:0] POS_HUMID_WH = 5'd14;
  localparam logic [4:0] POS_HUMID_FR = 5'd15;

  typedef enum logic [3:0] {
    PH_HUNT_FIRST  = 4'b0001,
    PH_HUNT_SECOND = 4'b0010,
    PH_COLLECT     = 4'b0100,
    PH_FULL        = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] concentration_high;
    logic [7:0] concentration_low;
    logic [6:0] temperature_whole;
    logic [7:0] temperature_fraction;
    logic [7:0] humidity_whole;
    logic [7:0] humidity_fraction;
  } result_t;

endpackage

// ===== design/asfp_parse.sv =====
// ---------------------------------------------------------------------------
// Frame parser core
// Header hunt, byte counting and capture of the fields of interest.
// ---------------------------------------------------------------------------
module asfp_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        rx_byte,
  output logic              full,
  output logic              fire,
  output asfp_pkg::result_t result
);

  asfp_pkg::phase_t phase;
  asfp_pkg::phase_t phase_next;
  logic [4:0]       byte_count;
  logic [4:0]       byte_count_next;
  logic [4:0]       count_inc;

  logic [7:0] conc_hi;
  logic [7:0] conc_lo;
  logic [7:0] temp_wh;
  logic [7:0] temp_fr;
  logic [7:0] humid_wh;
  logic [7:0] humid_fr;

  assign count_inc = byte_count + 5'd1;
  assign full      = (phase == asfp_pkg::PH_FULL);
  assign fire      = take && full;

  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    case (phase)
      asfp_pkg::PH_HUNT_FIRST: begin
        if (rx_byte == asfp_pkg::HDR_FIRST) begin
          phase_next      = asfp_pkg::PH_HUNT_SECOND;
          byte_count_next = count_inc;
        end else begin
          byte_count_next = '0;
        end
      end
      asfp_pkg::PH_HUNT_SECOND: begin
        if (rx_byte == asfp_pkg::HDR_SECOND) begin
          phase_next      = asfp_pkg::PH_COLLECT;
          byte_count_next = count_inc;
        end else begin
          phase_next      = asfp_pkg::PH_HUNT_FIRST;
          byte_count_next = '0;
        end
      end
      asfp_pkg::PH_COLLECT: begin
        byte_count_next = count_inc;
        if (count_inc > asfp_pkg::LAST_INDEX) begin
          phase_next = asfp_pkg::PH_FULL;
        end
      end
      asfp_pkg::PH_FULL: begin
        phase_next      = asfp_pkg::PH_HUNT_FIRST;
        byte_count_next = '0;
      end
      default: begin
        phase_next      = asfp_pkg::PH_HUNT_FIRST;
        byte_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= asfp_pkg::PH_HUNT_FIRST;
      byte_count <= '0;
    end else if (take) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
    end
  end

  // Every kept position is rewritten during a full frame before it is read.
  always_ff @(posedge clk) begin
    if (take && phase == asfp_pkg::PH_COLLECT) begin
      if (byte_count == asfp_pkg::POS_CONC_HI)  conc_hi  <= rx_byte;
      if (byte_count == asfp_pkg::POS_CONC_LO)  conc_lo  <= rx_byte;
      if (byte_count == asfp_pkg::POS_TEMP_WH)  temp_wh  <= rx_byte;
      if (byte_count == asfp_pkg::POS_TEMP_FR)  temp_fr  <= rx_byte;
      if (byte_count == asfp_pkg::POS_HUMID_WH) humid_wh <= rx_byte;
      if (byte_count == asfp_pkg::POS_HUMID_FR) humid_fr <= rx_byte;
    end
  end

  logic [7:0] temp_masked;
  assign temp_masked = temp_wh & asfp_pkg::TEMP_MASK;

  always_comb begin
    result.concentration_high   = conc_hi;
    result.concentration_low    = conc_lo;
    result.temperature_whole    = temp_masked[6:0];
    result.temperature_fraction = temp_fr;
    result.humidity_whole       = humid_wh;
    result.humidity_fraction    = humid_fr;
  end

endmodule

// ===== design/asfp_out.sv =====
// ---------------------------------------------------------------------------
// Result register
// Holds one parsed reading until the downstream side takes it.
// ---------------------------------------------------------------------------
module asfp_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  asfp_pkg::result_t result,
  input  logic              out_stall,
  output logic              out_valid,
  output asfp_pkg::result_t held
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held <= result;
    end
  end

endmodule

// ===== design/air_sensor_frame_parser_top.sv =====
// ---------------------------------------------------------------------------
// Air sensor frame parser, top level
// Finds 0x3C 0x02 framed packets in a received byte stream and reports the
// gas concentration, temperature and humidity fields of each full frame.
// ---------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   -------   --------------------   -------------------------------------
//   input     in_valid / in_stall    rx_byte
//   output    out_valid / out_stall  concentration_high, concentration_low,
//                                    temperature_whole, temperature_fraction,
//                                    humidity_whole, humidity_fraction
//
// One input word is taken every cycle while in_stall is low; the parser state
// registers update in the cycle of acceptance, and a reading appears on the
// output in the cycle after the trigger word that follows a full 17-byte frame.
// Reset (rst, synchronous, active high) returns the parser to header hunting
// and empties the result register.
// The input stalls only when the trigger word arrives while an earlier reading
// is still held and stalled at the output; all other words flow on.
// ---------------------------------------------------------------------------
module air_sensor_frame_parser_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] concentration_high,
  output logic [7:0] concentration_low,
  output logic [6:0] temperature_whole,
  output logic [7:0] temperature_fraction,
  output logic [7:0] humidity_whole,
  output logic [7:0] humidity_fraction
);

  `include "air_sensor_frame_parser_top_macros.svh"

  logic              take;
  logic              full;
  logic              fire;
  asfp_pkg::result_t result;
  asfp_pkg::result_t held;

  // A trigger word needs a free result register; other words never wait.
  assign in_stall = full && out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  asfp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .full    (full),
    .fire    (fire),
    .result  (result)
  );

  asfp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .result    (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .held      (held)
  );

  assign concentration_high   = held.concentration_high;
  assign concentration_low    = held.concentration_low;
  assign temperature_whole    = held.temperature_whole;
  assign temperature_fraction = held.temperature_fraction;
  assign humidity_whole       = held.humidity_whole;
  assign humidity_fraction    = held.humidity_fraction;

  // The input is held back only behind a waiting reading at a full frame.
  `ASFP_ASSERT_IMP(a_stall_cause, clk, rst, in_stall, full && out_valid && out_stall, "input stalled without a waiting reading")
  // A taken trigger word always yields a reading in the next cycle.
  `ASFP_ASSERT_NXT(a_fire_shows, clk, rst, in_valid && !in_stall && full, out_valid, "trigger word produced no reading")
  // A delivered reading is not shown twice unless a new frame completed.
  `ASFP_ASSERT_NXT(a_no_repeat, clk, rst, out_valid && !out_stall && !fire, !out_valid, "reading repeated after delivery")

endmodule
